>>> rtl/htip_pkg.sv
// ----------------------------------------------------------------------------
// htip_pkg: shared types, constants and tables of the hand tip finder
// Widths of the datapath stages, border codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package htip_pkg;

    localparam int ROT_W  = 33;   // rotation CORDIC x/y, Q30 plus headroom
    localparam int ANG_W  = 23;   // rotation residual angle, 1/16384 degree
    localparam int PT_W   = 48;   // corner coordinates, Q31 scale
    localparam int SUM_W  = 49;   // sum of two corners
    localparam int VEC_W  = 52;   // vectoring CORDIC x/y
    localparam int VZ_W   = 24;   // vectoring accumulated angle
    localparam int STG_W  = 5;    // CORDIC stage index
    localparam int N_STG  = 16;   // CORDIC stages

    localparam logic [2:0] BORDER_NONE   = 3'd0;
    localparam logic [2:0] BORDER_BOTTOM = 3'd1;
    localparam logic [2:0] BORDER_TOP    = 3'd2;
    localparam logic [2:0] BORDER_RIGHT  = 3'd3;
    localparam logic [2:0] BORDER_LEFT   = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    localparam logic signed [ROT_W-1:0] CORDIC_X0 = 33'sd652032874;
    localparam logic signed [VZ_W-1:0]  DEG180_FINE = 24'sd2949120;

    typedef struct packed {
        logic [2:0]  code;
        logic        neg;
        logic [13:0] w;
        logic [13:0] h;
        logic [13:0] cx;
        logic [13:0] cy;
        logic [13:0] gx;
        logic [13:0] gy;
    } t_side;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
    } t_pt;

    typedef t_pt [3:0] t_quad;

    typedef struct packed {
        logic [2:0]  code;
        logic [13:0] gx;
        logic [13:0] gy;
    } t_cside;

    typedef struct packed {
        logic [2:0]         code;
        logic               zero;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } t_vside;

    // arctangent of 2^-i in 1/16384 degree
    function automatic logic signed [ANG_W-1:0] atan_at(input logic [STG_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 23'sd737280;
            5'd1:  v = 23'sd435242;
            5'd2:  v = 23'sd229970;
            5'd3:  v = 23'sd116736;
            5'd4:  v = 23'sd58595;
            5'd5:  v = 23'sd29326;
            5'd6:  v = 23'sd14667;
            5'd7:  v = 23'sd7334;
            5'd8:  v = 23'sd3667;
            5'd9:  v = 23'sd1833;
            5'd10: v = 23'sd917;
            5'd11: v = 23'sd458;
            5'd12: v = 23'sd229;
            5'd13: v = 23'sd115;
            5'd14: v = 23'sd57;
            5'd15: v = 23'sd29;
            5'd16: v = 23'sd14;
            5'd17: v = 23'sd7;
            5'd18: v = 23'sd4;
            5'd19: v = 23'sd2;
            5'd20: v = 23'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/hand_tip_from_rotated_rect.sv
// ----------------------------------------------------------------------------
// hand_tip_from_rotated_rect: hand tip finder for one blob per item
// Border test, rotated-box corners by CORDIC, corner sort, tip and tip angle.
// ----------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------------
//  blob in   | i_in_valid / o_in_ready      | box, rotated box, angle, centroid
//  tip out   | o_out_valid / i_out_ready    | border code, tip, tip angle
//  config    | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
//  One item enters per cycle unless the output stalls; the stages are the two
//  16-cell CORDIC chains and the entry, multiply, corner, five sort, tip, fold and output stages.
//  Reset clears all stage valid bits and loads 640 x 480 as the image size.
//  A result held at the output freezes the whole chain until it is taken.
// ----------------------------------------------------------------------------
module hand_tip_from_rotated_rect (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [10:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [9:0]         i_box_left,
    input  logic [9:0]         i_box_top,
    input  logic [9:0]         i_box_right,
    input  logic [9:0]         i_box_bottom,
    input  logic [13:0]        i_rot_center_x,
    input  logic [13:0]        i_rot_center_y,
    input  logic [13:0]        i_rot_width,
    input  logic [13:0]        i_rot_height,
    input  logic signed [14:0] i_blob_angle,
    input  logic [13:0]        i_centroid_x,
    input  logic [13:0]        i_centroid_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_border_code,
    output logic               o_tip_valid,
    output logic signed [15:0] o_tip_x,
    output logic signed [15:0] o_tip_y,
    output logic signed [14:0] o_tip_angle
);
    import htip_pkg::*;

    logic en;
    logic [10:0] r_img_w, r_img_h;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd640;
            r_img_h <= 11'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_img_w <= i_cfg_wdata;
                REG_HEIGHT: r_img_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- entry stage: border test and angle reduction ----
    logic [11:0]         h_m1, w_m1;
    logic [2:0]          code;
    logic signed [15:0]  a0, a1, a2;
    logic                neg;
    logic signed [ANG_W-1:0] z0;
    t_side               side0;

    always_comb begin
        h_m1 = {1'b0, r_img_h} - 12'd1;
        w_m1 = {1'b0, r_img_w} - 12'd1;
        if ({2'b0, i_box_bottom} == h_m1)      code = BORDER_BOTTOM;
        else if (i_box_top == 10'd1)           code = BORDER_TOP;
        else if ({2'b0, i_box_right} == w_m1)  code = BORDER_RIGHT;
        else if (i_box_left == 10'd1)          code = BORDER_LEFT;
        else                                   code = BORDER_NONE;

        a0 = 16'(i_blob_angle) + 16'sd5760;
        a1 = (a0 >= 16'sd11520) ? a0 - 16'sd23040 : a0;
        neg = 1'b0;
        a2 = a1;
        if (a1 > 16'sd5760) begin
            a2 = a1 - 16'sd11520;
            neg = 1'b1;
        end else if (a1 < -16'sd5760) begin
            a2 = a1 + 16'sd11520;
            neg = 1'b1;
        end
        z0 = ANG_W'(a2) <<< 8;

        side0.code = code;
        side0.neg  = neg;
        side0.w    = i_rot_width;
        side0.h    = i_rot_height;
        side0.cx   = i_rot_center_x;
        side0.cy   = i_rot_center_y;
        side0.gx   = i_centroid_x;
        side0.gy   = i_centroid_y;
    end

    logic                    r_s0_vld;
    logic signed [ANG_W-1:0] r_s0_z;
    t_side                   r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_z    <= z0;
            r_s0_side <= side0;
        end
    end

    // ---- rotation CORDIC chain: cos and sin of angle + 90 degrees ----
    logic                    rv [0:N_STG];
    logic signed [ROT_W-1:0] rx [0:N_STG];
    logic signed [ROT_W-1:0] ry [0:N_STG];
    logic signed [ANG_W-1:0] rz [0:N_STG];
    t_side                   rs [0:N_STG];

    assign rv[0] = r_s0_vld;
    assign rx[0] = CORDIC_X0;
    assign ry[0] = '0;
    assign rz[0] = r_s0_z;
    assign rs[0] = r_s0_side;

    for (genvar g = 0; g < N_STG; g++) begin : g_rot
        htip_rot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (rv[g]),
            .i_stage (STG_W'(g)),
            .i_x     (rx[g]),
            .i_y     (ry[g]),
            .i_z     (rz[g]),
            .i_side  (rs[g]),
            .o_vld   (rv[g+1]),
            .o_x     (rx[g+1]),
            .o_y     (ry[g+1]),
            .o_z     (rz[g+1]),
            .o_side  (rs[g+1])
        );
    end

    // ---- multiply stage ----
    logic signed [ROT_W-1:0] cv, sv;
    logic signed [PT_W-1:0]  n_wc, n_ws, n_hc, n_hs;
    logic signed [PT_W-1:0]  r_wc, r_ws, r_hc, r_hs;
    logic                    r_m_vld;
    t_side                   r_m_side;

    always_comb begin
        cv   = rs[N_STG].neg ? -rx[N_STG] : rx[N_STG];
        sv   = rs[N_STG].neg ? -ry[N_STG] : ry[N_STG];
        n_wc = $signed({1'b0, rs[N_STG].w}) * cv;
        n_ws = $signed({1'b0, rs[N_STG].w}) * sv;
        n_hc = $signed({1'b0, rs[N_STG].h}) * cv;
        n_hs = $signed({1'b0, rs[N_STG].h}) * sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= rv[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wc     <= n_wc;
            r_ws     <= n_ws;
            r_hc     <= n_hc;
            r_hs     <= n_hs;
            r_m_side <= rs[N_STG];
        end
    end

    // ---- corner stage ----
    logic signed [PT_W-1:0] cxs, cys;
    t_quad                  n_q, r_c_q;
    t_cside                 n_cs, r_c_side;
    logic                   r_c_vld;

    always_comb begin
        cxs = $signed({3'b0, r_m_side.cx, 31'b0});
        cys = $signed({3'b0, r_m_side.cy, 31'b0});
        n_q[0].x = -r_wc - r_hs + cxs;
        n_q[0].y = -r_ws + r_hc + cys;
        n_q[1].x =  r_wc - r_hs + cxs;
        n_q[1].y =  r_ws + r_hc + cys;
        n_q[2].x =  r_wc + r_hs + cxs;
        n_q[2].y =  r_ws - r_hc + cys;
        n_q[3].x = -r_wc + r_hs + cxs;
        n_q[3].y = -r_ws - r_hc + cys;
        n_cs.code = r_m_side.code;
        n_cs.gx   = r_m_side.gx;
        n_cs.gy   = r_m_side.gy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_q    <= n_q;
            r_c_side <= n_cs;
        end
    end

    // ---- sort chain: only the steps that settle the first two corners ----
    localparam logic [1:0] SORT_A [0:4] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1};
    localparam logic [1:0] SORT_B [0:4] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3};

    logic   sv_v [0:5];
    t_quad  sq   [0:5];
    t_cside ss   [0:5];

    assign sv_v[0] = r_c_vld;
    assign sq[0]   = r_c_q;
    assign ss[0]   = r_c_side;

    for (genvar k = 0; k < 5; k++) begin : g_sort
        htip_swap_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sv_v[k]),
            .i_ia    (SORT_A[k]),
            .i_ib    (SORT_B[k]),
            .i_q     (sq[k]),
            .i_side  (ss[k]),
            .o_vld   (sv_v[k+1]),
            .o_q     (sq[k+1]),
            .o_side  (ss[k+1])
        );
    end

    // ---- tip sum stage ----
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic                    r_t_vld;
    t_cside                  r_t_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (en) begin
            r_t_vld <= sv_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx     <= SUM_W'(sq[5][0].x) + SUM_W'(sq[5][1].x);
            r_sy     <= SUM_W'(sq[5][0].y) + SUM_W'(sq[5][1].y);
            r_t_side <= ss[5];
        end
    end

    // ---- fold stage: round the tip, set up vectoring ----
    logic signed [SUM_W-1:0] rnd_x, rnd_y;
    logic signed [16:0]      tx17, ty17;
    logic signed [VEC_W-1:0] dx, dy, fx, fy;
    logic signed [VZ_W-1:0]  base;
    t_vside                  vs0;
    logic                    r_f_vld;
    logic signed [VEC_W-1:0] r_fx, r_fy;
    logic signed [VZ_W-1:0]  r_fz;
    t_vside                  r_f_side;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767)       r = 16'sd32767;
        else if (v < -17'sd32768) r = -16'sd32768;
        else                      r = v[15:0];
        return r;
    endfunction

    always_comb begin
        rnd_x = r_sx + SUM_W'(64'sd2147483648);
        rnd_y = r_sy + SUM_W'(64'sd2147483648);
        tx17  = rnd_x[SUM_W-1:32];
        ty17  = rnd_y[SUM_W-1:32];
        dx = VEC_W'(r_sx) - $signed({6'b0, r_t_side.gx, 32'b0});
        dy = VEC_W'(r_sy) - $signed({6'b0, r_t_side.gy, 32'b0});
        if (dx < 0) begin
            fx   = -dx;
            fy   = -dy;
            base = (dy >= 0) ? DEG180_FINE : -DEG180_FINE;
        end else begin
            fx   = dx;
            fy   = dy;
            base = '0;
        end
        vs0.code = r_t_side.code;
        vs0.zero = (dx == 0) && (dy == 0);
        vs0.tx   = sat16(tx17);
        vs0.ty   = sat16(ty17);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fx     <= fx;
            r_fy     <= fy;
            r_fz     <= base;
            r_f_side <= vs0;
        end
    end

    // ---- vectoring CORDIC chain: angle of tip minus centroid ----
    logic                    vv [0:N_STG];
    logic signed [VEC_W-1:0] vx [0:N_STG];
    logic signed [VEC_W-1:0] vy [0:N_STG];
    logic signed [VZ_W-1:0]  vz [0:N_STG];
    t_vside                  vsd [0:N_STG];

    assign vv[0]  = r_f_vld;
    assign vx[0]  = r_fx;
    assign vy[0]  = r_fy;
    assign vz[0]  = r_fz;
    assign vsd[0] = r_f_side;

    for (genvar g = 0; g < N_STG; g++) begin : g_vec
        htip_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vv[g]),
            .i_stage (STG_W'(g)),
            .i_x     (vx[g]),
            .i_y     (vy[g]),
            .i_z     (vz[g]),
            .i_side  (vsd[g]),
            .o_vld   (vv[g+1]),
            .o_x     (vx[g+1]),
            .o_y     (vy[g+1]),
            .o_z     (vz[g+1]),
            .o_side  (vsd[g+1])
        );
    end

    // ---- output register ----
    logic signed [VZ_W-1:0] zr;
    logic signed [15:0]     ta16;
    logic signed [14:0]     ta;
    t_vside                 fo;
    logic                   r_o_vld;
    logic [2:0]             r_code;
    logic                   r_tv;
    logic signed [15:0]     r_tx, r_ty;
    logic signed [14:0]     r_ta;

    always_comb begin
        fo   = vsd[N_STG];
        zr   = (vz[N_STG] + VZ_W'(128)) >>> 8;
        ta16 = zr[15:0];
        if (ta16 > 16'sd11520)       ta = 15'sd11520;
        else if (ta16 < -16'sd11520) ta = -15'sd11520;
        else                         ta = ta16[14:0];
        if (fo.zero) ta = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= vv[N_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_code <= fo.code;
            // drop the tip of a blob that touches no border
            if (fo.code == BORDER_NONE) begin
                r_tv <= 1'b0;
                r_tx <= '0;
                r_ty <= '0;
                r_ta <= '0;
            end else begin
                r_tv <= 1'b1;
                r_tx <= fo.tx;
                r_ty <= fo.ty;
                r_ta <= ta;
            end
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_border_code = r_code;
    assign o_tip_valid   = r_tv;
    assign o_tip_x       = r_tx;
    assign o_tip_y       = r_ty;
    assign o_tip_angle   = r_ta;

    // ---- assertions ----
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while output is stalled");

    a_tip_valid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tip_valid == (o_border_code != BORDER_NONE)))
        else $error("tip valid disagrees with border code");

    a_no_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_border_code == BORDER_NONE)) |->
        (o_tip_x == 16'sd0 && o_tip_y == 16'sd0 && o_tip_angle == 15'sd0))
        else $error("nonzero tip without border");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_tip_angle <= 15'sd11520 && o_tip_angle >= -15'sd11520))
        else $error("tip angle out of range");

    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_f_vld))
        else $error("pipeline moved during a stall");

endmodule

>>> rtl/htip_rot_cell.sv
// ----------------------------------------------------------------------------
// htip_rot_cell: one stage of the rotation CORDIC
// Turns (x, y) by +-atan(2^-i) toward a zero residual angle, registered.
// ----------------------------------------------------------------------------
module htip_rot_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic [htip_pkg::STG_W-1:0]         i_stage,
    input  logic signed [htip_pkg::ROT_W-1:0]  i_x,
    input  logic signed [htip_pkg::ROT_W-1:0]  i_y,
    input  logic signed [htip_pkg::ANG_W-1:0]  i_z,
    input  htip_pkg::t_side                    i_side,
    output logic                               o_vld,
    output logic signed [htip_pkg::ROT_W-1:0]  o_x,
    output logic signed [htip_pkg::ROT_W-1:0]  o_y,
    output logic signed [htip_pkg::ANG_W-1:0]  o_z,
    output htip_pkg::t_side                    o_side
);
    import htip_pkg::*;

    logic                    r_vld;
    logic signed [ROT_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ANG_W-1:0] r_z, n_z;
    t_side                   r_side;
    logic signed [ROT_W-1:0] sh_x, sh_y;

    always_comb begin
        sh_y = i_y >>> i_stage;
        sh_x = i_x >>> i_stage;
        if (i_z >= 0) begin
            n_x = i_x - sh_y;
            n_y = i_y + sh_x;
            n_z = i_z - atan_at(i_stage);
        end else begin
            n_x = i_x + sh_y;
            n_y = i_y - sh_x;
            n_z = i_z + atan_at(i_stage);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

>>> rtl/htip_swap_cell.sv
// ----------------------------------------------------------------------------
// htip_swap_cell: one compare-exchange step of the corner sort
// Orders two corners by y or x as the border code asks; ties keep the order.
// ----------------------------------------------------------------------------
module htip_swap_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [1:0]         i_ia,
    input  logic [1:0]         i_ib,
    input  htip_pkg::t_quad    i_q,
    input  htip_pkg::t_cside   i_side,
    output logic               o_vld,
    output htip_pkg::t_quad    o_q,
    output htip_pkg::t_cside   o_side
);
    import htip_pkg::*;

    logic   r_vld;
    t_quad  r_q, n_q;
    t_cside r_side;
    t_pt    pa, pb;
    logic   swap;

    always_comb begin
        pa = i_q[i_ia];
        pb = i_q[i_ib];
        case (i_side.code)
            BORDER_BOTTOM: swap = pa.y > pb.y;
            BORDER_TOP:    swap = pa.y < pb.y;
            BORDER_RIGHT:  swap = pa.x > pb.x;
            default:       swap = pa.x < pb.x;
        endcase
        n_q = i_q;
        if (swap) begin
            n_q[i_ia] = pb;
            n_q[i_ib] = pa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q    <= n_q;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_q    = r_q;
    assign o_side = r_side;

endmodule

>>> rtl/htip_vec_cell.sv
// ----------------------------------------------------------------------------
// htip_vec_cell: one stage of the vectoring CORDIC
// Drives y toward zero and accumulates the angle turned, registered.
// ----------------------------------------------------------------------------
module htip_vec_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic [htip_pkg::STG_W-1:0]         i_stage,
    input  logic signed [htip_pkg::VEC_W-1:0]  i_x,
    input  logic signed [htip_pkg::VEC_W-1:0]  i_y,
    input  logic signed [htip_pkg::VZ_W-1:0]   i_z,
    input  htip_pkg::t_vside                   i_side,
    output logic                               o_vld,
    output logic signed [htip_pkg::VEC_W-1:0]  o_x,
    output logic signed [htip_pkg::VEC_W-1:0]  o_y,
    output logic signed [htip_pkg::VZ_W-1:0]   o_z,
    output htip_pkg::t_vside                   o_side
);
    import htip_pkg::*;

    logic                    r_vld;
    logic signed [VEC_W-1:0] r_x, r_y, n_x, n_y, sh_x, sh_y;
    logic signed [VZ_W-1:0]  r_z, n_z, step;
    t_vside                  r_side;

    always_comb begin
        sh_y = i_y >>> i_stage;
        sh_x = i_x >>> i_stage;
        step = VZ_W'(atan_at(i_stage));
        if (i_y >= 0) begin
            n_x = i_x + sh_y;
            n_y = i_y - sh_x;
            n_z = i_z + step;
        end else begin
            n_x = i_x - sh_y;
            n_y = i_y + sh_x;
            n_z = i_z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the hand tip finder
// Directed and random blobs under changing image sizes and handshake idling;
// every accepted result is compared against a bit-exact tip predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import htip_pkg::*;

    typedef struct {
        logic [9:0]         bl, bt, br, bb;
        logic [13:0]        cx, cy, w, h;
        logic signed [14:0] ang;
        logic [13:0]        gx, gy;
    } blob_t;

    typedef struct {
        logic [2:0]         code;
        logic               valid;
        logic signed [15:0] tx, ty;
        logic signed [14:0] ta;
    } tip_t;

    class tip_scoreboard;
        tip_t        pending[$];
        int unsigned img_w = 640, img_h = 480;
        int          errors = 0;

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endfunction

        function longint atan_step(int i);
            longint t[16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                              3667, 1833, 917, 458, 229, 115, 57, 29};
            return t[i];
        endfunction

        function void cos_sin(int a, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit neg;
            x = 652032874; y = 0; neg = 0;
            while (a >= 11520) a -= 23040;
            while (a < -11520) a += 23040;
            if (a > 5760) begin a -= 11520; neg = 1; end
            else if (a < -5760) begin a += 11520; neg = 1; end
            z = longint'(a) * 256;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin x -= dx; y += dy; z -= atan_step(i); end
                else begin x += dx; y -= dy; z += atan_step(i); end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function longint vec_angle(longint dx, longint dy);
            longint base, z, sx, sy;
            base = 0; z = 0;
            if (dx == 0 && dy == 0) return 0;
            if (dx < 0) begin
                base = dy >= 0 ? 2949120 : -2949120;
                dx = -dx; dy = -dy;
            end
            for (int i = 0; i < 16; i++) begin
                sx = dy >>> i; sy = dx >>> i;
                if (dy >= 0) begin dx += sx; dy -= sy; z += atan_step(i); end
                else begin dx -= sx; dy += sy; z -= atan_step(i); end
            end
            return base + z;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_blob(blob_t b);
            tip_t   r;
            longint c, s, px[4], py[4], tmpx, tmpy, sx, sy, ta;
            bit     sw;
            r = '{BORDER_NONE, 0, 0, 0, 0};
            if (longint'(b.bb) == longint'(img_h) - 1) r.code = BORDER_BOTTOM;
            else if (b.bt == 1) r.code = BORDER_TOP;
            else if (longint'(b.br) == longint'(img_w) - 1) r.code = BORDER_RIGHT;
            else if (b.bl == 1) r.code = BORDER_LEFT;
            if (r.code != BORDER_NONE) begin
                cos_sin(int'(b.ang) + 5760, c, s);
                px = '{-longint'(b.w), b.w, b.w, -longint'(b.w)};
                py = '{b.h, b.h, -longint'(b.h), -longint'(b.h)};
                for (int i = 0; i < 4; i++) begin
                    tmpx = px[i] * c - py[i] * s + longint'(b.cx) * (64'sd1 << 31);
                    tmpy = px[i] * s + py[i] * c + longint'(b.cy) * (64'sd1 << 31);
                    px[i] = tmpx; py[i] = tmpy;
                end
                // exchange sort, ties keep the earlier corner first
                for (int i = 0; i < 4; i++)
                    for (int j = i + 1; j < 4; j++) begin
                        case (r.code)
                            BORDER_BOTTOM: sw = py[i] > py[j];
                            BORDER_TOP:    sw = py[i] < py[j];
                            BORDER_RIGHT:  sw = px[i] > px[j];
                            default:       sw = px[i] < px[j];
                        endcase
                        if (sw) begin
                            tmpx = px[i]; px[i] = px[j]; px[j] = tmpx;
                            tmpy = py[i]; py[i] = py[j]; py[j] = tmpy;
                        end
                    end
                sx = px[0] + px[1];
                sy = py[0] + py[1];
                r.valid = 1;
                r.tx = 16'(clip((sx + (64'sd1 << 31)) >>> 32, -32768, 32767));
                r.ty = 16'(clip((sy + (64'sd1 << 31)) >>> 32, -32768, 32767));
                ta = vec_angle(sx - longint'(b.gx) * (64'sd1 << 32),
                               sy - longint'(b.gy) * (64'sd1 << 32));
                r.ta = 15'(clip((ta + 128) >>> 8, -11520, 11520));
            end
            pending.push_back(r);
        endfunction

        function void check_tip(tip_t got);
            tip_t e;
            if (pending.size() == 0) begin
                report("unexpected item", got.code, -1);
                return;
            end
            e = pending.pop_front();
            if (got.code !== e.code) report("border_code", got.code, e.code);
            if (got.valid !== e.valid) report("tip_valid", got.valid, e.valid);
            if (got.tx !== e.tx) report("tip_x", got.tx, e.tx);
            if (got.ty !== e.ty) report("tip_y", got.ty, e.ty);
            if (got.ta !== e.ta) report("tip_angle", got.ta, e.ta);
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_idx = REG_WIDTH;
    logic [10:0]        i_cfg_wdata = '0;
    logic               i_in_valid = 0, o_in_ready;
    logic [9:0]         i_box_left = '0, i_box_top = '0, i_box_right = '0, i_box_bottom = '0;
    logic [13:0]        i_rot_center_x = '0, i_rot_center_y = '0;
    logic [13:0]        i_rot_width = '0, i_rot_height = '0;
    logic signed [14:0] i_blob_angle = '0;
    logic [13:0]        i_centroid_x = '0, i_centroid_y = '0;
    logic               o_out_valid, i_out_ready = 0;
    logic [2:0]         o_border_code;
    logic               o_tip_valid;
    logic signed [15:0] o_tip_x, o_tip_y;
    logic signed [14:0] o_tip_angle;

    tip_scoreboard tips = new();
    int  send_idle_pct = 0, recv_stall_pct = 0;
    bit  hold_off = 0;
    bit  draining = 0;

    hand_tip_from_rotated_rect i_dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // receiver: random stalls plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tips.check_tip('{o_border_code, o_tip_valid, o_tip_x, o_tip_y, o_tip_angle});
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_wdata <= val[10:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_WIDTH) tips.img_w = 32'(val[10:0]);
        else if (idx == REG_HEIGHT) tips.img_h = 32'(val[10:0]);
        @(posedge i_clk);
    endtask

    // valid stays high from one item to the next unless the sender idles
    task automatic send_blob(blob_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_box_left <= b.bl; i_box_top <= b.bt; i_box_right <= b.br; i_box_bottom <= b.bb;
        i_rot_center_x <= b.cx; i_rot_center_y <= b.cy;
        i_rot_width <= b.w; i_rot_height <= b.h;
        i_blob_angle <= b.ang; i_centroid_x <= b.gx; i_centroid_y <= b.gy;
        do @(posedge i_clk); while (!o_in_ready);
        tips.note_blob(b);
    endtask

    function automatic blob_t rand_blob();
        blob_t b;
        int    pick;
        b.bl = 10'($urandom); b.bt = 10'($urandom);
        b.br = 10'($urandom); b.bb = 10'($urandom);
        b.cx = 14'($urandom); b.cy = 14'($urandom);
        b.w = 14'($urandom); b.h = 14'($urandom);
        b.gx = 14'($urandom); b.gy = 14'($urandom);
        b.ang = ($urandom_range(9) == 0) ? 15'($urandom)
                                          : 15'($signed($urandom_range(23040)) - 11520);
        if ($urandom_range(3) == 0) begin
            b.w = 14'($urandom_range(200)); b.h = 14'($urandom_range(200));
        end
        // mostly touching blobs so the tip path is exercised
        pick = $urandom_range(9);
        case (pick)
            0: b.bb = 10'(tips.img_h - 1);
            1, 2: b.bt = 1;
            3, 4: b.br = 10'(tips.img_w - 1);
            5, 6: b.bl = 1;
            7: begin b.bb = 10'(tips.img_h - 1); b.bt = 1; b.bl = 1; end
            default: ;
        endcase
        return b;
    endfunction

    task automatic drain();
        i_in_valid <= 0;
        while (tips.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        for (int k = 0; k < n; k++) send_blob(rand_blob());
    endtask

    initial begin
        blob_t b;
        int    sizes[5][2] = '{'{640, 480}, '{2, 2}, '{1024, 1024}, '{0, 0}, '{1024, 2}};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: each border, extremes, ties, wrapped angles
        b = '{0, 0, 0, 479, 0, 0, 0, 0, 0, 0, 0};
        send_blob(b);
        b = '{1023, 1023, 1023, 479, 16383, 16383, 16383, 16383, 15'sd11520, 16383, 16383};
        send_blob(b);
        b = '{0, 1, 0, 0, 8000, 8000, 100, 100, 15'sd0, 8000, 8000};
        send_blob(b);   // tip on centroid is possible; square gives sort ties
        b = '{0, 0, 639, 0, 0, 16383, 16383, 0, -15'sd11520, 0, 16383};
        send_blob(b);
        b = '{1, 0, 0, 0, 5000, 3000, 400, 160, 15'sd5760, 0, 0};
        send_blob(b);
        b = '{1, 1, 639, 479, 100, 100, 50, 70, -15'sd5760, 200, 0};
        send_blob(b);
        b = '{2, 2, 2, 2, 100, 100, 50, 70, 15'sd3000, 200, 0};
        send_blob(b);   // no border
        b = '{1, 0, 0, 0, 100, 100, 50, 70, 15'h4000, 200, 0};
        send_blob(b);   // most negative angle
        b = '{1, 0, 0, 0, 100, 100, 50, 70, 15'h3FFF, 0, 200};
        send_blob(b);
        b = '{1, 0, 0, 0, 0, 0, 16383, 16383, 15'sd2880, 16383, 0};
        send_blob(b);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_WIDTH, sizes[ph][0]);
            write_reg(REG_HEIGHT, sizes[ph][1]);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 80; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 80; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            if (ph == 0) begin
                fork
                    begin hold_off = 1; repeat (300) @(posedge i_clk); hold_off = 0; end
                    run_random(240);
                join
            end else begin
                run_random(240);
            end
            drain();
        end
        write_reg(2'd3, 11'h7FF);  // unused index, must be ignored
        send_idle_pct = 0; recv_stall_pct = 0;
        run_random(20);
        drain();

        if (tips.errors == 0 && tips.pending.size() == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_top failed");
        $finish;
    end
endmodule
